// ===== rtl/cmfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfc_pkg
// Shared widths, register indexes, reset values and stage types of the
// color match frame counter.
// ----------------------------------------------------------------------------
package cmfc_pkg;

  // field widths
  localparam int COLOR_W    = 8;
  localparam int RADIUS_W   = 9;
  localparam int SQ_W       = 2 * COLOR_W;
  localparam int DIST_W     = 18;
  localparam int COUNT_W    = 20;
  localparam int SUM_W      = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_RED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 3'd3;

  // register reset values
  localparam logic [COLOR_W-1:0]  RST_REF_RED      = 8'd200;
  localparam logic [COLOR_W-1:0]  RST_REF_GREEN    = 8'd160;
  localparam logic [COLOR_W-1:0]  RST_REF_BLUE     = 8'd180;
  localparam logic [RADIUS_W-1:0] RST_MATCH_RADIUS = 9'd20;

  // reference color and squared radius as seen by the datapath
  typedef struct packed {
    logic [COLOR_W-1:0] ref_red;
    logic [COLOR_W-1:0] ref_green;
    logic [COLOR_W-1:0] ref_blue;
    logic [DIST_W-1:0]  lim2;
  } cmfc_cfg_t;

  // square stage contents handed to the accumulator
  typedef struct packed {
    logic               valid;
    logic               eof;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [SQ_W-1:0]    sq_red;
    logic [SQ_W-1:0]    sq_green;
    logic [SQ_W-1:0]    sq_blue;
  } cmfc_sq_t;

endpackage

// ===== rtl/cmfc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfc_cfg_regs
// Configuration registers; the match radius is stored squared so the
// datapath compares against it directly.
// ----------------------------------------------------------------------------
module cmfc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cmfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output cmfc_pkg::cmfc_cfg_t             cfg
);
  import cmfc_pkg::*;

  logic [COLOR_W-1:0] ref_red_r, ref_red_nxt;
  logic [COLOR_W-1:0] ref_green_r, ref_green_nxt;
  logic [COLOR_W-1:0] ref_blue_r, ref_blue_nxt;
  logic [DIST_W-1:0]  lim2_r, lim2_nxt;
  logic [DIST_W-1:0]  radius_ext;
  logic               wr_en;

  assign cfg_ready  = 1'b1;
  assign wr_en      = cfg_valid & cfg_ready;
  assign radius_ext = {{(DIST_W-RADIUS_W){1'b0}}, cfg_data[RADIUS_W-1:0]};

  // register decode
  always_comb begin
    ref_red_nxt   = ref_red_r;
    ref_green_nxt = ref_green_r;
    ref_blue_nxt  = ref_blue_r;
    lim2_nxt      = lim2_r;
    if (wr_en) begin
      case (cfg_index)
        REG_REF_RED:      ref_red_nxt   = cfg_data[COLOR_W-1:0];
        REG_REF_GREEN:    ref_green_nxt = cfg_data[COLOR_W-1:0];
        REG_REF_BLUE:     ref_blue_nxt  = cfg_data[COLOR_W-1:0];
        REG_MATCH_RADIUS: lim2_nxt      = radius_ext * radius_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_red_r   <= RST_REF_RED;
      ref_green_r <= RST_REF_GREEN;
      ref_blue_r  <= RST_REF_BLUE;
      lim2_r      <= DIST_W'(RST_MATCH_RADIUS) * DIST_W'(RST_MATCH_RADIUS);
    end else begin
      ref_red_r   <= ref_red_nxt;
      ref_green_r <= ref_green_nxt;
      ref_blue_r  <= ref_blue_nxt;
      lim2_r      <= lim2_nxt;
    end
  end

  assign cfg.ref_red   = ref_red_r;
  assign cfg.ref_green = ref_green_r;
  assign cfg.ref_blue  = ref_blue_r;
  assign cfg.lim2      = lim2_r;

endmodule

// ===== rtl/cmfc_sqdist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfc_sqdist
// Pixel input register and squared channel difference stage.
// ----------------------------------------------------------------------------
module cmfc_sqdist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cmfc_pkg::COLOR_W-1:0] in_red,
  input  logic [cmfc_pkg::COLOR_W-1:0] in_green,
  input  logic [cmfc_pkg::COLOR_W-1:0] in_blue,
  input  logic                         in_end_of_frame,
  input  cmfc_pkg::cmfc_cfg_t          cfg,
  input  logic                         acc_ready,
  output cmfc_pkg::cmfc_sq_t           sq
);
  import cmfc_pkg::*;

  logic               in_valid_r;
  logic               in_eof_r;
  logic [COLOR_W-1:0] in_red_r, in_green_r, in_blue_r;
  logic               sq_valid_r;
  logic               sq_eof_r;
  logic [COLOR_W-1:0] sq_pix_red_r, sq_pix_green_r, sq_pix_blue_r;
  logic [SQ_W-1:0]    sq_red_r, sq_green_r, sq_blue_r;
  logic [SQ_W-1:0]    sq_red_nxt, sq_green_nxt, sq_blue_nxt;
  logic               sq_load;
  logic               in_load;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    logic [SQ_W-1:0]    de;
    d  = (a > b) ? (a - b) : (b - a);
    de = {{(SQ_W-COLOR_W){1'b0}}, d};
    return de * de;
  endfunction

  // stage advance: square stage moves when empty or drained downstream
  assign sq_load  = ~sq_valid_r | acc_ready;
  assign in_load  = ~in_valid_r | sq_load;
  assign in_stall = ~in_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_eof_r   <= in_end_of_frame;
      in_red_r   <= in_red;
      in_green_r <= in_green;
      in_blue_r  <= in_blue;
    end
  end

  // squared differences to the reference color
  always_comb begin
    sq_red_nxt   = sq_diff(in_red_r, cfg.ref_red);
    sq_green_nxt = sq_diff(in_green_r, cfg.ref_green);
    sq_blue_nxt  = sq_diff(in_blue_r, cfg.ref_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (sq_load) begin
      sq_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_load && in_valid_r) begin
      sq_eof_r       <= in_eof_r;
      sq_pix_red_r   <= in_red_r;
      sq_pix_green_r <= in_green_r;
      sq_pix_blue_r  <= in_blue_r;
      sq_red_r       <= sq_red_nxt;
      sq_green_r     <= sq_green_nxt;
      sq_blue_r      <= sq_blue_nxt;
    end
  end

  assign sq.valid    = sq_valid_r;
  assign sq.eof      = sq_eof_r;
  assign sq.red      = sq_pix_red_r;
  assign sq.green    = sq_pix_green_r;
  assign sq.blue     = sq_pix_blue_r;
  assign sq.sq_red   = sq_red_r;
  assign sq.sq_green = sq_green_r;
  assign sq.sq_blue  = sq_blue_r;

endmodule

// ===== rtl/cmfc_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfc_accum
// Distance compare, saturating frame accumulators and the result register.
// ----------------------------------------------------------------------------
module cmfc_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmfc_pkg::cmfc_sq_t           sq,
  input  cmfc_pkg::cmfc_cfg_t          cfg,
  output logic                         acc_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cmfc_pkg::COUNT_W-1:0] out_match_count,
  output logic [cmfc_pkg::COUNT_W-1:0] out_pixel_count,
  output logic [cmfc_pkg::SUM_W-1:0]   out_sum_red,
  output logic [cmfc_pkg::SUM_W-1:0]   out_sum_green,
  output logic [cmfc_pkg::SUM_W-1:0]   out_sum_blue,
  output logic                         out_detected
);
  import cmfc_pkg::*;

  logic [COUNT_W-1:0] match_total_r, match_total_nxt;
  logic [COUNT_W-1:0] pixel_total_r, pixel_total_nxt;
  logic [SUM_W-1:0]   red_total_r, red_total_nxt;
  logic [SUM_W-1:0]   green_total_r, green_total_nxt;
  logic [SUM_W-1:0]   blue_total_r, blue_total_nxt;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_match_r, out_pixel_r;
  logic [SUM_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic               out_det_r, det_nxt;
  logic [DIST_W-1:0]  dist2;
  logic               is_match;
  logic               fire;

  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0]   s,
                                               input logic [COLOR_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {{(SUM_W+1-COLOR_W){1'b0}}, v};
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  // an end-of-frame pixel waits only while the previous result is held
  assign acc_ready = ~(sq.eof & out_valid_r & out_stall);
  assign fire      = sq.valid & acc_ready;

  // distance compare and next totals
  always_comb begin
    dist2 = DIST_W'(sq.sq_red) + DIST_W'(sq.sq_green) + DIST_W'(sq.sq_blue);
    is_match        = (dist2 <= cfg.lim2);
    pixel_total_nxt = count_inc(pixel_total_r);
    match_total_nxt = is_match ? count_inc(match_total_r) : match_total_r;
    red_total_nxt   = sum_add(red_total_r, sq.red);
    green_total_nxt = sum_add(green_total_r, sq.green);
    blue_total_nxt  = sum_add(blue_total_r, sq.blue);
    det_nxt         = (match_total_nxt > (pixel_total_nxt >> 1));
  end

  // frame accumulators, cleared after the end-of-frame pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_total_r <= '0;
      pixel_total_r <= '0;
      red_total_r   <= '0;
      green_total_r <= '0;
      blue_total_r  <= '0;
    end else if (fire) begin
      if (sq.eof) begin
        match_total_r <= '0;
        pixel_total_r <= '0;
        red_total_r   <= '0;
        green_total_r <= '0;
        blue_total_r  <= '0;
      end else begin
        match_total_r <= match_total_nxt;
        pixel_total_r <= pixel_total_nxt;
        red_total_r   <= red_total_nxt;
        green_total_r <= green_total_nxt;
        blue_total_r  <= blue_total_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && sq.eof) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && sq.eof) begin
      out_match_r <= match_total_nxt;
      out_pixel_r <= pixel_total_nxt;
      out_red_r   <= red_total_nxt;
      out_green_r <= green_total_nxt;
      out_blue_r  <= blue_total_nxt;
      out_det_r   <= det_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_match_r;
  assign out_pixel_count = out_pixel_r;
  assign out_sum_red     = out_red_r;
  assign out_sum_green   = out_green_r;
  assign out_sum_blue    = out_blue_r;
  assign out_detected    = out_det_r;

`ifndef NO_ASSERTIONS
  // accumulators are empty right after a frame closes
  a_clear_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sq.eof) |=> (pixel_total_r == '0 && match_total_r == '0))
    else $error("accumulators not cleared after end of frame");

  // a result appears only after an end-of-frame pixel was taken
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && sq.eof))
    else $error("result raised without end-of-frame pixel");

  // matches never outnumber pixels
  a_match_le_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    match_total_r <= pixel_total_r)
    else $error("match count above pixel count");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(fire && sq.eof))
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/color_match_frame_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_match_frame_counter
// Per-frame color match counter with channel sums and a majority detect flag.
// ----------------------------------------------------------------------------
// Accepts one RGB24 pixel per clock. Each pixel passes an input register, a
// stage that squares the channel differences to the reference color, and an
// accumulate stage that compares the distance against the squared radius and
// updates saturating counters and channel sums. The pixel flagged end of
// frame produces one result, held in an output register until taken; totals
// then restart at zero. Input stalls only when an end-of-frame pixel reaches
// the accumulate stage while the previous result is still held. Configuration
// writes take effect at the next clock; the user must make them only while no
// pixels are in flight, as the block does not enforce this.
module color_match_frame_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cmfc_pkg::COLOR_W-1:0]    in_red,
  input  logic [cmfc_pkg::COLOR_W-1:0]    in_green,
  input  logic [cmfc_pkg::COLOR_W-1:0]    in_blue,
  input  logic                            in_end_of_frame,
  // frame result
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cmfc_pkg::COUNT_W-1:0]    out_match_count,
  output logic [cmfc_pkg::COUNT_W-1:0]    out_pixel_count,
  output logic [cmfc_pkg::SUM_W-1:0]      out_sum_red,
  output logic [cmfc_pkg::SUM_W-1:0]      out_sum_green,
  output logic [cmfc_pkg::SUM_W-1:0]      out_sum_blue,
  output logic                            out_detected,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cmfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cmfc_pkg::*;

  cmfc_cfg_t cfg;
  cmfc_sq_t  sq;
  logic      acc_ready;

  // configuration registers
  cmfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register and squared differences
  cmfc_sqdist u_sqdist (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_end_of_frame (in_end_of_frame),
    .cfg             (cfg),
    .acc_ready       (acc_ready),
    .sq              (sq)
  );

  // accumulators and result register
  cmfc_accum u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .sq              (sq),
    .cfg             (cfg),
    .acc_ready       (acc_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_count (out_match_count),
    .out_pixel_count (out_pixel_count),
    .out_sum_red     (out_sum_red),
    .out_sum_green   (out_sum_green),
    .out_sum_blue    (out_sum_blue),
    .out_detected    (out_detected)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the color match frame counter.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus process and driven on falling edges.
// Every accepted pixel is folded into a local copy of the frame totals at the
// rising edge. An end-of-frame pixel queues the expected frame result, and
// each result taken from the block is compared with the oldest one, field by
// field. Settings change only while the block is drained. The run covers the
// exact-radius boundary, the majority boundary, zero and full radius, and
// ignored register writes.
module tb_top;
  import cmfc_pkg::*;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               eof;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] pixel_count;
    logic [SUM_W-1:0]   sum_red;
    logic [SUM_W-1:0]   sum_green;
    logic [SUM_W-1:0]   sum_blue;
    logic               detected;
  } frame_totals_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COLOR_W-1:0]    in_red = '0;
  logic [COLOR_W-1:0]    in_green = '0;
  logic [COLOR_W-1:0]    in_blue = '0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    out_match_count;
  logic [COUNT_W-1:0]    out_pixel_count;
  logic [SUM_W-1:0]      out_sum_red;
  logic [SUM_W-1:0]      out_sum_green;
  logic [SUM_W-1:0]      out_sum_blue;
  logic                  out_detected;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pending pixels and expected frame results
  pixel_t        pixel_q[$];
  frame_totals_t frame_q[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  logic pixel_taken = 1'b0;

  // local copy of the settings
  logic [COLOR_W-1:0]  cur_red    = RST_REF_RED;
  logic [COLOR_W-1:0]  cur_green  = RST_REF_GREEN;
  logic [COLOR_W-1:0]  cur_blue   = RST_REF_BLUE;
  logic [RADIUS_W-1:0] cur_radius = RST_MATCH_RADIUS;

  // running totals of the open frame
  int unsigned match_tally = 0;
  int unsigned pixel_tally = 0;
  int unsigned red_tally   = 0;
  int unsigned green_tally = 0;
  int unsigned blue_tally  = 0;

  color_match_frame_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_count (out_match_count),
    .out_pixel_count (out_pixel_count),
    .out_sum_red     (out_sum_red),
    .out_sum_green   (out_sum_green),
    .out_sum_blue    (out_sum_blue),
    .out_detected    (out_detected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sq_gap(input logic [COLOR_W-1:0] a,
                                         input logic [COLOR_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic int unsigned sat_sum(input int unsigned s, input int unsigned v);
    return (s + v > SUM_MAX) ? SUM_MAX : s + v;
  endfunction

  // fold one pixel into the frame totals; returns 1 when the frame closes
  function automatic bit fold_pixel(input pixel_t px, output frame_totals_t totals);
    int unsigned dist2;
    int unsigned lim2;
    dist2 = sq_gap(px.red, cur_red) + sq_gap(px.green, cur_green)
          + sq_gap(px.blue, cur_blue);
    lim2 = cur_radius * cur_radius;
    pixel_tally = (pixel_tally >= COUNT_MAX) ? COUNT_MAX : pixel_tally + 1;
    if (dist2 <= lim2) begin
      match_tally = (match_tally >= COUNT_MAX) ? COUNT_MAX : match_tally + 1;
    end
    red_tally   = sat_sum(red_tally, px.red);
    green_tally = sat_sum(green_tally, px.green);
    blue_tally  = sat_sum(blue_tally, px.blue);
    totals = '0;
    if (!px.eof) begin
      return 1'b0;
    end
    totals.match_count = COUNT_W'(match_tally);
    totals.pixel_count = COUNT_W'(pixel_tally);
    totals.sum_red     = SUM_W'(red_tally);
    totals.sum_green   = SUM_W'(green_tally);
    totals.sum_blue    = SUM_W'(blue_tally);
    totals.detected    = (match_tally > (pixel_tally >> 1));
    match_tally = 0;
    pixel_tally = 0;
    red_tally   = 0;
    green_tally = 0;
    blue_tally  = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // pixel driver, falling edge
  always @(negedge clk) begin : driver
    pixel_t px;
    if (!in_valid || pixel_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pixel_q.pop_front();
        in_red          <= px.red;
        in_green        <= px.green;
        in_blue         <= px.blue;
        in_end_of_frame <= px.eof;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor and checker, rising edge
  always @(posedge clk) begin : monitor
    frame_totals_t want;
    pixel_t px;
    pixel_taken <= in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame result, expected none, actual match %0d pixels %0d",
                 $time, out_match_count, out_pixel_count);
        mismatches++;
      end else begin
        want = frame_q.pop_front();
        check_field("match_count", want.match_count, out_match_count);
        check_field("pixel_count", want.pixel_count, out_pixel_count);
        check_field("sum_red", want.sum_red, out_sum_red);
        check_field("sum_green", want.sum_green, out_sum_green);
        check_field("sum_blue", want.sum_blue, out_sum_blue);
        check_field("detected", want.detected, out_detected);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      px = '{red: in_red, green: in_green, blue: in_blue, eof: in_end_of_frame};
      if (fold_pixel(px, want)) begin
        frame_q.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_px(input int r, input int g, input int b, input bit eof);
    pixel_q.push_back('{red: COLOR_W'(r), green: COLOR_W'(g), blue: COLOR_W'(b), eof: eof});
  endtask

  // one register write transaction; settings copy follows the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REF_RED:      cur_red    = val[COLOR_W-1:0];
      REG_REF_GREEN:    cur_green  = val[COLOR_W-1:0];
      REG_REF_BLUE:     cur_blue   = val[COLOR_W-1:0];
      REG_MATCH_RADIUS: cur_radius = val;
      default: ;
    endcase
  endtask

  // full settings change, with one write to an unused index and random top bits
  task automatic load_settings(input int r, input int g, input int b, input int radius);
    write_reg(REG_REF_RED,   {1'($urandom_range(1)), 8'(r)});
    write_reg(REG_REF_GREEN, {1'($urandom_range(1)), 8'(g)});
    write_reg(REG_REF_BLUE,  {1'($urandom_range(1)), 8'(b)});
    write_reg(3'($urandom_range(2**CFG_IDX_W - 1, REG_MATCH_RADIUS + 1)),
              9'($urandom_range(2**CFG_DATA_W - 1)));
    write_reg(REG_MATCH_RADIUS, 9'(radius));
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // wait until every pixel is in and every frame result is out
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] nudge(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    return (v < 0) ? '0 : (v > 255) ? '1 : COLOR_W'(v);
  endfunction

  // random frames, mostly short, colors biased toward the reference color
  task automatic queue_frames(input int n);
    int left;
    int len;
    int near_pct;
    int spread;
    pixel_t px;
    left = n;
    spread = (cur_radius * 3) / 5 + 1;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(48, 1) : $urandom_range(6, 1);
      if (len > left) len = left;
      near_pct = $urandom_range(100);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < near_pct) begin
          px.red   = nudge(cur_red, spread);
          px.green = nudge(cur_green, spread);
          px.blue  = nudge(cur_blue, spread);
        end else begin
          px.red   = COLOR_W'($urandom_range(255));
          px.green = COLOR_W'($urandom_range(255));
          px.blue  = COLOR_W'($urandom_range(255));
        end
        px.eof = (i == len - 1);
        pixel_q.push_back(px);
      end
      left -= len;
    end
  endtask

  // stimulus
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    recv_idle_pct = 58;

    // reset settings: exact match, radius boundary, majority boundary
    push_px(200, 160, 180, 1);
    push_px(220, 160, 180, 0);
    push_px(221, 160, 180, 1);
    push_px(212, 176, 180, 0);
    push_px(212, 176, 181, 0);
    push_px(0, 0, 0, 0);
    push_px(255, 255, 255, 1);
    push_px(200, 160, 160, 0);
    push_px(200, 160, 180, 1);
    queue_frames(500);
    wait_drained();

    // zero radius: only the exact color matches
    load_settings(0, 0, 0, 0);
    push_px(0, 0, 0, 0);
    push_px(0, 0, 1, 0);
    push_px(0, 0, 0, 1);
    queue_frames(250);
    wait_drained();

    // sender idles heavily, receiver lightly
    send_idle_pct = 58;
    recv_idle_pct = 17;

    // full radius: every color matches
    load_settings(255, 255, 255, 511);
    push_px(0, 0, 0, 1);
    push_px(0, 255, 0, 1);
    queue_frames(250);
    wait_drained();

    load_settings($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(60));
    queue_frames(250);
    wait_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;

    load_settings($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(200));
    queue_frames(250);
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== color_match_frame_counter.f =====
rtl/cmfc_pkg.sv
rtl/cmfc_cfg_regs.sv
rtl/cmfc_sqdist.sv
rtl/cmfc_accum.sv
rtl/color_match_frame_counter.sv
verif/tb_top.sv
